>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL modules.
// No dependencies; each module that uses them has i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock, off while in reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> hw/rtl/i2a_pkg.sv
// Shared types and constants for the signed 64-bit to decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int DIGITS     = 20;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int DIG_IDX_W  = 5;
    localparam int BITS_PER_STEP = 8;
    localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);
    localparam int QDEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    // One queued request: sign flag and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

endpackage

>>> hw/rtl/signed_int64_to_decimal_ascii.sv
// Signed 64-bit integer to decimal ASCII text, one character per output request.
//
// Input channel: i_valid / o_stall carry i_value (64-bit two's complement);
// a request is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_character (7-bit ASCII) and
// o_last_char, which marks the final character of each number. A negative
// number starts with '-', zero gives a single '0', there are no leading zeros;
// the most negative value comes out as "-9223372036854775808".
// Flow: a front register takes the value and forms sign and magnitude, a
// short queue (QDEPTH entries) decouples it from the back end. The back end
// loads a number in S_IDLE, runs double dabble in S_CONV (8 bits per cycle),
// finds the top digit in S_COUNT, then sends one character per cycle in S_EMIT
// while the receiver does not stall. It takes the next number from the queue
// only after it has issued the last character of the current one.
// While the receiver stalls, the output register holds its character and the
// back end waits with its next one; new values keep entering until the queue and the front register are full.
// Reset (synchronous, active low) empties the queue and drops any partly sent
// number.
// Depends on i2a_pkg, i2a_front, i2a_fifo, i2a_back.
`timescale 1ns / 1ps

module signed_int64_to_decimal_ascii #(
    parameter int QDEPTH = i2a_pkg::QDEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [i2a_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [i2a_pkg::CHAR_W-1:0]        o_character,
    output logic                              o_last_char
);
    import i2a_pkg::*;

    t_job f_job;
    t_job q_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Front: input register plus sign / magnitude split.
    i2a_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .o_push   (push),
        .o_job    (f_job),
        .i_q_full (q_full)
    );

    // Queue between front and back.
    i2a_fifo #(
        .QDEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    // Back: BCD conversion and character sequencing.
    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule

>>> hw/rtl/i2a_fifo.sv
// Short request queue between the front and back stages.
// Depends on i2a_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2a_fifo #(
    parameter int QDEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  i2a_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output i2a_pkg::t_job o_data,
    output logic          o_empty
);
    import i2a_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_pop && o_empty)
    `ASSERT_NEVER(a_cnt_range, r_cnt > CNT_FULL)

endmodule

>>> hw/rtl/i2a_front.sv
// Front stage: takes the input value, splits sign and magnitude, queues it.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [i2a_pkg::VALUE_W-1:0] i_value,
    output logic                        o_push,
    output i2a_pkg::t_job               o_job,
    input  logic                        i_q_full
);
    import i2a_pkg::*;

    logic r_valid, n_valid;
    t_job r_job;
    logic take;

    // Holding register frees when the queue takes its content.
    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign take    = i_valid && !o_stall;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Most negative value negates to 2^63, which is right as unsigned.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job.neg <= i_value[VALUE_W-1];
            r_job.mag <= i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                            : VALUE_W'(i_value);
        end
    end

endmodule

>>> hw/rtl/i2a_back.sv
// Back stage: binary to BCD (8 bits per cycle), digit count, character output.
// Depends on i2a_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2a_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  i2a_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [i2a_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last_char
);
    import i2a_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_COUNT = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_W-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [STEP_CNT_W-1:0] r_step, n_step;
    logic [DIG_IDX_W-1:0]  r_idx, n_idx;
    logic                  r_sign, n_sign;
    logic                  r_ov, n_ov;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;
    logic                  slot_free;
    logic [BCD_W-1:0]      dab;
    logic [DIG_IDX_W-1:0]  top_idx;
    logic [3:0]            cur_dig;

    // One shift-and-add-3 step of double dabble.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
        logic [BCD_W-1:0] t;
        t = b;
        for (int d = 0; d < DIGITS; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    always_comb begin
        dab = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            dab = dabble(dab, r_bin[VALUE_W-1-k]);
        end
    end

    // Highest nonzero digit; zero keeps index 0 so a lone '0' comes out.
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                top_idx = DIG_IDX_W'(d);
            end
        end
    end

    assign cur_dig   = r_bcd[{r_idx, 2'b00} +: 4];
    assign slot_free = !r_ov || !i_stall;
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        n_idx   = r_idx;
        n_sign  = r_sign;
        n_ov    = r_ov && i_stall;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_bin   = i_job.mag;
                    n_bcd   = '0;
                    n_sign  = i_job.neg;
                    n_step  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = dab;
                n_bin  = {r_bin[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
                n_step = r_step + 1'b1;
                if (r_step == STEP_CNT_W'(CONV_STEPS - 1)) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_idx   = top_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (r_sign) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_sign = 1'b0;
                    end else begin
                        n_char = CHAR_ZERO + CHAR_W'(cur_dig);
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_step <= n_step;
        r_idx  <= n_idx;
        r_sign <= n_sign;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_ov;
    assign o_character = r_char;
    assign o_last_char = r_last;

    `ASSERT_IMPL(a_minus_not_last, o_valid && (o_character == CHAR_MINUS), !o_last_char)
    `ASSERT_IMPL(a_digit_range, o_valid && (o_character != CHAR_MINUS),
                 (o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 7'd9))
    `ASSERT_IMPL(a_emit_digit_bcd, (r_state == S_EMIT) && !r_sign, cur_dig <= 4'd9)

endmodule

>>> tb/sv/signed_int64_to_decimal_ascii_test.sv
// Testbench for signed_int64_to_decimal_ascii: checks the decimal text of each value.
// Depends on i2a_pkg and the signed_int64_to_decimal_ascii RTL; needs nothing else.
`timescale 1ns / 1ps

module signed_int64_to_decimal_ascii_test;

    import i2a_pkg::*;

    // Generous cap on the whole run, well beyond the slowest correct run, in which
    // every value waits out random receiver stalls.
    localparam int TIMEOUT_NS = 5_000_000;
    // Quiet time after the last owed character, to cover anything still in flight.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    // One expected character of the text.
    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_char;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_valid;
    logic                       i_stall;
    logic [CHAR_W-1:0]          o_character;
    logic                       o_last_char;

    // Characters still owed by the block, oldest first.
    t_char pending_chars[$];
    t_char want_char;
    int    fails;

    // Idle percentages for the sender and the receiver, set per phase.
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    // Long receiver hold-off: the test posts a length, the receiver counts it.
    int unsigned hold_len;
    int unsigned hold_left;

    signed_int64_to_decimal_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Decimal text of a value: optional '-' then the digits of the unsigned
    // magnitude, no leading zeros. The most negative value negates to itself,
    // and read as unsigned that is exactly 9223372036854775808.
    task automatic predict_text(input logic signed [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_q[$];
        t_char              c;
        begin
            mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
            if (value[VALUE_W-1]) begin
                c.character = CHAR_MINUS;
                c.last_char = 1'b0;
                pending_chars.push_back(c);
            end
            // Digits come out least significant first; zero still yields one.
            do begin
                digit_q.push_front(4'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            while (digit_q.size() != 0) begin
                c.character = CHAR_ZERO + CHAR_W'(digit_q.pop_front());
                c.last_char = (digit_q.size() == 0);
                pending_chars.push_back(c);
            end
        end
    endtask

    // Offer one value. Called at a falling edge and returns at one, so valid is
    // assigned at most once per step; a valid that stays high is never dropped.
    task automatic send_value(input logic signed [VALUE_W-1:0] value);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid <= 1'b1;
            i_value <= value;
            // Taken at the first rising edge where the block is not stalling.
            do
                @(posedge i_clk);
            while (o_stall);
            predict_text(value);
            @(negedge i_clk);
        end
    endtask

    // Mix of full-range values, tiny ones, random magnitudes and values right
    // around powers of ten, where the digit count changes.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] r;
        int unsigned        sel;
        int unsigned        k;
        begin
            r = {$urandom, $urandom};
            sel = $urandom_range(3);
            case (sel)
                0: begin
                end
                1: begin
                    r = $urandom_range(20);
                end
                2: begin
                    r = r >> $urandom_range(63);
                end
                default: begin
                    r = 1;
                    k = $urandom_range(18);
                    repeat (k) r = r * 10;
                    r = r + $urandom_range(2) - 1;
                end
            endcase
            if (sel != 0 && $urandom_range(1) == 1)
                r = -r;
            return r;
        end
    endfunction

    task automatic send_random(input int count);
        begin
            repeat (count) send_value(rand_value());
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Hold the input side until every owed character has come out.
    task automatic wait_drained();
        begin
            wait (pending_chars.size() == 0);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
    endtask

    task automatic test_directed_values();
        logic signed [VALUE_W-1:0] vals[] = '{
            64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10,
            64'sd99, 64'sd100, 64'sd12345, -64'sd67890,
            64'sh7FFF_FFFF_FFFF_FFFF,       // largest positive, 19 digits
            64'sh8000_0000_0000_0000,       // most negative, fixed 20-char text
            64'sh8000_0000_0000_0001,
            64'sh7FFF_FFFF_FFFF_FFFE,
            64'sd1000000000000000000, -64'sd1000000000000000000,
            64'sd999999999999999999, -64'sd999999999999999999,
            64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
            64'sd4294967296, -64'sd4294967295
        };
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
            foreach (vals[i]) send_value(vals[i]);
            i_valid <= 1'b0;
            @(negedge i_clk);
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
            send_random(130);
            wait_drained();
        end
    endtask

    task automatic test_sender_gaps();
        begin
            send_idle_pct = 69;
            stall_pct     = 0;
            send_random(110);
            wait_drained();
        end
    endtask

    task automatic test_receiver_stall();
        begin
            send_idle_pct = 0;
            stall_pct     = 69;
            send_random(110);
            wait_drained();
        end
    endtask

    task automatic test_both_idle();
        begin
            send_idle_pct = 34;
            stall_pct     = 34;
            send_random(110);
            wait_drained();
        end
    endtask

    // Receiver freezes for a long stretch while values keep coming, so the
    // queue fills and o_stall has to push back on the sender.
    task automatic test_output_holdoff();
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
            hold_len      = HOLD_CYCLES;
            send_random(30);
            wait_drained();
        end
    endtask

    // Sender stops dead after each group of one to four values until the text is
    // all out, so each group starts from an empty block.
    task automatic test_drain_pause();
        begin
            send_idle_pct = 0;
            stall_pct     = 20;
            repeat (6) begin
                send_random($urandom_range(1, 4));
                wait (pending_chars.size() == 0);
                // Back onto the falling edge before driving again.
                @(negedge i_clk);
            end
            stall_pct = 0;
            wait_drained();
        end
    endtask

    // Receiver side: random stalls, or a counted hold-off when one is posted.
    always @(negedge i_clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every character taken is compared with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: actual %h last %b", o_character, o_last_char);
                fails++;
            end else begin
                want_char = pending_chars.pop_front();
                if (o_character !== want_char.character) begin
                    $error("character: expected %h actual %h",
                           want_char.character, o_character);
                    fails++;
                end
                if (o_last_char !== want_char.last_char) begin
                    $error("last_char: expected %b actual %b",
                           want_char.last_char, o_last_char);
                    fails++;
                end
            end
        end
    end

    initial begin
        fails         = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 0;
        hold_left     = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_value       = '0;
        i_stall       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_values();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stall();
        test_both_idle();
        test_output_holdoff();
        test_drain_pause();

        // Anything still owed here never showed up.
        if (pending_chars.size() != 0) begin
            $error("characters never received: expected 0 actual %0d", pending_chars.size());
            fails++;
        end
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_fifo.sv
hw/rtl/i2a_front.sv
hw/rtl/i2a_back.sv
hw/rtl/signed_int64_to_decimal_ascii.sv
tb/sv/signed_int64_to_decimal_ascii_test.sv
